// File: sv/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants for the integer to base digits unit
// widths, register indexes, character codes and the alphabet lookup
// ----------------------------------------------------------------------------
package itd_pkg;

  // input and output word widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  // alphabet and radix
  localparam int MAX_BASE = 16;
  localparam int DIGIT_W  = $clog2(MAX_BASE);
  localparam int RADIX_W  = $clog2(MAX_BASE) + 1;
  localparam int ALPHA_W  = MAX_BASE * CHAR_W;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 8'd2;

  // digit stack
  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = STACK_AW + 1;

  // divider: quotient bits retired per cycle and divider steps per digit
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // characters with a meaning of their own
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [RADIX_W-1:0] base_length;
    logic [ALPHA_W-1:0] alphabet;
  } cfg_t;

  // alphabet byte for a digit
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alphabet,
                                                   input logic [DIGIT_W-1:0] idx);
    return alphabet[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

// File: sv/itd_in_if.sv
// ----------------------------------------------------------------------------
// itd_in_if: input channel
// carries one signed integer word per handshake
// ----------------------------------------------------------------------------
interface itd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itd_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: sv/itd_out_if.sv
// ----------------------------------------------------------------------------
// itd_out_if: output channel
// carries one character word per handshake, marked on the last of a number
// ----------------------------------------------------------------------------
interface itd_out_if;
  logic                         valid;
  logic                         ready;
  logic [itd_pkg::CHAR_W-1:0]   character;
  logic                         last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// File: sv/itd_cfg_if.sv
// ----------------------------------------------------------------------------
// itd_cfg_if: configuration write channel
// carries a register index and write data per handshake
// ----------------------------------------------------------------------------
interface itd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [itd_pkg::CFG_IDX_W-1:0]    index;
  logic [itd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/itd_ram.sv
// ----------------------------------------------------------------------------
// itd_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module itd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/itd_div.sv
// ----------------------------------------------------------------------------
// itd_div: shared radix divider step
// retires four quotient bits per use by restoring compare and subtract
// ----------------------------------------------------------------------------
module itd_div (
  input  logic [itd_pkg::DIGIT_W-1:0]  rem_in,
  input  logic [itd_pkg::DIV_BITS-1:0] bits_in,
  input  logic [itd_pkg::RADIX_W-1:0]  radix,
  output logic [itd_pkg::DIGIT_W-1:0]  rem_out,
  output logic [itd_pkg::DIV_BITS-1:0] quot_out
);

  // remainder stays below the radix, so each trial value fits radix width
  always_comb begin
    logic [itd_pkg::DIGIT_W-1:0] r;
    logic [itd_pkg::RADIX_W-1:0] t;
    r        = rem_in;
    quot_out = '0;
    for (int b = itd_pkg::DIV_BITS - 1; b >= 0; b--) begin
      t = {r, bits_in[b]};
      if (t >= radix) begin
        t           = t - radix;
        quot_out[b] = 1'b1;
      end
      r = t[itd_pkg::DIGIT_W-1:0];
    end
    rem_out = r;
  end

endmodule

// File: sv/itd_cfg.sv
// ----------------------------------------------------------------------------
// itd_cfg: configuration registers
// holds the radix and the sixteen alphabet bytes, written over the cfg channel
// ----------------------------------------------------------------------------
module itd_cfg (
  input  logic          clk,
  input  logic          rst,
  itd_cfg_if.sink       cfg,
  output itd_pkg::cfg_t cfg_out
);

  logic [itd_pkg::RADIX_W-1:0]    base_length;
  logic [itd_pkg::CFG_DATA_W-1:0] alphabet_low;
  logic [itd_pkg::CFG_DATA_W-1:0] alphabet_high;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length   <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        itd_pkg::REG_BASE_LENGTH:   base_length   <= cfg.data[itd_pkg::RADIX_W-1:0];
        itd_pkg::REG_ALPHABET_LOW:  alphabet_low  <= cfg.data;
        itd_pkg::REG_ALPHABET_HIGH: alphabet_high <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg_out.base_length = base_length;
  assign cfg_out.alphabet    = {alphabet_high, alphabet_low};

endmodule

// File: sv/integer_to_base_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_unit: signed integer to radix character string
// sequencer around a shared divider step and a digit stack memory
//
//   channel  dir  modport  payload
//   cfg      in   sink     index[7:0], data[63:0]
//   din      in   sink     value[31:0] signed
//   dout     out  source   character[7:0], last_char
//
// an accepted word first checks the alphabet, one character per cycle,
// then divides out one digit at a time on the shared divider, then emits an
// optional sign and then the digit characters
// an invalid configuration consumes the word and emits nothing
// din is ready only when no word is in progress; dout stalls hold the sequencer
// synchronous reset clears the sequencer state, digit count, running quotient and output valid
// ----------------------------------------------------------------------------
module integer_to_base_digits_unit (
  input  logic      clk,
  input  logic      rst,
  itd_cfg_if.sink   cfg,
  itd_in_if.sink    din,
  itd_out_if.source dout
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;

  itd_pkg::cfg_t cfg_q;

  logic [2:0]                    state;
  logic                          neg;
  logic [itd_pkg::VALUE_W-1:0]   running_quotient;
  logic [itd_pkg::DIGIT_W-1:0]   rem;
  logic [itd_pkg::STEP_W-1:0]    step;
  logic [itd_pkg::CNT_W-1:0]     digit_count;
  logic [itd_pkg::DIGIT_W-1:0]   chk_idx;
  logic                          out_valid;
  logic [itd_pkg::CHAR_W-1:0]    out_char;
  logic                          out_last;

  logic [itd_pkg::DIGIT_W-1:0]   rem_next;
  logic [itd_pkg::DIV_BITS-1:0]  quot_bits;
  logic [itd_pkg::VALUE_W-1:0]   quotient_next;
  logic [itd_pkg::CNT_W-1:0]     count_next;
  logic [itd_pkg::CNT_W-1:0]     count_m1;
  logic [itd_pkg::DIGIT_W-1:0]   rd_digit;
  logic                          ram_we;
  logic [itd_pkg::CHAR_W-1:0]    chk_char;
  logic                          chk_bad;
  logic                          chk_last;
  logic                          radix_ok;
  logic [itd_pkg::VALUE_W-1:0]   magnitude;

  itd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_q)
  );

  // shared divider works on the top nibble of the running quotient
  itd_div u_div (
    .rem_in   (rem),
    .bits_in  (running_quotient[itd_pkg::VALUE_W-1 -: itd_pkg::DIV_BITS]),
    .radix    (cfg_q.base_length),
    .rem_out  (rem_next),
    .quot_out (quot_bits)
  );

  assign quotient_next = {running_quotient[itd_pkg::VALUE_W-itd_pkg::DIV_BITS-1:0], quot_bits};
  assign count_next    = digit_count + 1'b1;
  assign count_m1      = digit_count - 1'b1;
  assign ram_we        = (state == ST_DIV) && (step == itd_pkg::STEP_W'(itd_pkg::DIV_STEPS - 1));

  // digit stack, least significant digit at entry 0
  itd_ram #(
    .WIDTH (itd_pkg::DIGIT_W),
    .DEPTH (itd_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[itd_pkg::STACK_AW-1:0]),
    .wdata (rem_next),
    .raddr (count_m1[itd_pkg::STACK_AW-1:0]),
    .rdata (rd_digit)
  );

  // radix range and magnitude of the incoming word
  assign radix_ok  = (cfg_q.base_length >= itd_pkg::RADIX_W'(2)) &&
                     (cfg_q.base_length <= itd_pkg::RADIX_W'(itd_pkg::MAX_BASE));
  assign magnitude = din.value[itd_pkg::VALUE_W-1] ?
                     (itd_pkg::VALUE_W'(0) - itd_pkg::VALUE_W'(din.value)) :
                     itd_pkg::VALUE_W'(din.value);

  // alphabet check: one character against the sign codes and all earlier ones
  always_comb begin
    chk_char = itd_pkg::alpha_char(cfg_q.alphabet, chk_idx);
    chk_bad  = (chk_char == itd_pkg::CHAR_MINUS) || (chk_char == itd_pkg::CHAR_PLUS);
    for (int i = 0; i < itd_pkg::MAX_BASE; i++) begin
      if ((itd_pkg::DIGIT_W'(i) < chk_idx) &&
          (itd_pkg::alpha_char(cfg_q.alphabet, itd_pkg::DIGIT_W'(i)) == chk_char)) begin
        chk_bad = 1'b1;
      end
    end
    chk_last = ({1'b0, chk_idx} == cfg_q.base_length - 1'b1);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      digit_count      <= '0;
      running_quotient <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (din.valid) begin
            neg              <= din.value[itd_pkg::VALUE_W-1];
            running_quotient <= magnitude;
            chk_idx          <= '0;
            if (radix_ok) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          chk_idx <= chk_idx + 1'b1;
          if (chk_bad) begin
            state <= ST_IDLE;
          end else if (chk_last) begin
            rem         <= '0;
            step        <= '0;
            digit_count <= '0;
            state       <= ST_DIV;
          end
        end
        ST_DIV: begin
          running_quotient <= quotient_next;
          step             <= step + 1'b1;
          rem              <= rem_next;
          if (ram_we) begin
            rem         <= '0;
            digit_count <= count_next;
            if ((quotient_next == '0) ||
                (count_next == itd_pkg::CNT_W'(itd_pkg::STACK_DEPTH))) begin
              state <= ST_SIGN;
            end
          end
        end
        ST_SIGN: begin
          if (neg) begin
            out_valid <= 1'b1;
            out_char  <= itd_pkg::CHAR_MINUS;
            out_last  <= 1'b0;
            state     <= ST_WAIT;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          out_valid   <= 1'b1;
          out_char    <= itd_pkg::alpha_char(cfg_q.alphabet, rd_digit);
          out_last    <= (digit_count == itd_pkg::CNT_W'(1));
          digit_count <= count_m1;
          state       <= ST_WAIT;
        end
        ST_WAIT: begin
          if (dout.ready) begin
            out_valid <= 1'b0;
            state     <= (digit_count == '0) ? ST_IDLE : ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign din.ready      = (state == ST_IDLE);
  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last_char = out_last;

  // output word only shows while waiting for the sink
  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_WAIT))
    else $error("output valid outside wait state");

  // no new input word while a character is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !out_valid)
    else $error("input ready with output pending");

  // the last character of a number returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dout.ready && out_last) |=> (state == ST_IDLE))
    else $error("sequencer busy after last character");

  // partial remainder stays below the radix during division
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < cfg_q.base_length))
    else $error("remainder out of range");

  // digit count never passes the stack depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= itd_pkg::CNT_W'(itd_pkg::STACK_DEPTH))
    else $error("digit count overflow");

endmodule
